[hdl/sra_pkg.sv]
package sra_pkg;

	localparam int TABLE_ENTRIES_DEF = 32;

	localparam int KEY_W       = 32;
	localparam int TIME_W      = 32;
	localparam int COUNT_W     = 16;
	localparam int WIN_W       = 8;
	localparam int INDEX_W     = 5;
	localparam int IN_DATA_W   = KEY_W + TIME_W;
	localparam int OUT_DATA_W  = 24;
	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 16;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
	localparam logic [COUNT_W-1:0] THR_RESET = 16'd10;
	localparam logic [WIN_W-1:0]   WIN_RESET = 8'd2;

	localparam logic [CFG_INDEX_W-1:0] REG_ALARM_THRESHOLD = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_SECONDS  = 8'd1;

	typedef struct packed {
		logic [COUNT_W-1:0] alarm_threshold;
		logic [WIN_W-1:0]   window_seconds;
	} sra_cfg_t;

	typedef struct packed {
		logic               valid;
		logic               done;
		logic [KEY_W-1:0]   src_ip;
		logic [TIME_W-1:0]  now_seconds;
		logic               alarm;
		logic [COUNT_W-1:0] packet_count;
		logic [INDEX_W-1:0] entry_index;
		logic               new_source;
	} sra_token_t;

endpackage

[hdl/per_source_rate_alarm.sv]
// path: an input beat is registered by every cell in the chain, then by the output register
// throughput: one beat per cycle while the output is not stalled, one lookup token advances one cell per cycle
// output stall freezes the whole cell chain and holds s_tready low
// reset: all entries invalid, alarm_threshold = 10, window_seconds = 2
// config writes always ready, applied on the next edge
module per_source_rate_alarm
	import sra_pkg::*;
#(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_DATA_W-1:0]   s_tdata,   // src_ip, now_seconds
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_DATA_W-1:0]  m_tdata,   // alarm, packet_count, entry_index, new_source, table_full
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic                  advance;
	sra_cfg_t              cfg_q;
	sra_token_t            tok [TABLE_ENTRIES+1];
	sra_token_t            tail;
	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	assign advance   = !m_tvalid_q || m_tready;
	assign s_tready  = advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alarm_threshold <= THR_RESET;
			cfg_q.window_seconds  <= WIN_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ALARM_THRESHOLD: cfg_q.alarm_threshold <= cfg_data;
				REG_WINDOW_SECONDS:  cfg_q.window_seconds  <= cfg_data[WIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		tok[0]              = '0;
		tok[0].valid        = s_tvalid;
		tok[0].src_ip       = s_tdata[KEY_W-1:0];
		tok[0].now_seconds  = s_tdata[IN_DATA_W-1:KEY_W];
	end

	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		sra_cell #(
			.INDEX(i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.advance(advance),
			.cfg    (cfg_q),
			.tok_in (tok[i]),
			.tok_out(tok[i+1])
		);
	end

	assign tail = tok[TABLE_ENTRIES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			m_tvalid_q <= tail.valid;
		end
	end

	// token fields stay zero when no cell took it, which is the table full result
	always_ff @(posedge clk) begin
		if (advance) begin
			m_tdata_q <= {!tail.done, tail.new_source, tail.entry_index,
				tail.packet_count, tail.alarm};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

[hdl/sra_cell.sv]
module sra_cell
	import sra_pkg::*;
#(
	parameter int INDEX = 0
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  sra_cfg_t   cfg,
	input  sra_token_t tok_in,
	output sra_token_t tok_out
);

	logic               valid_q;
	logic [KEY_W-1:0]   key_q;
	logic [COUNT_W-1:0] count_q;
	logic [TIME_W-1:0]  start_q;
	sra_token_t         tok_q;

	logic               live;
	logic               hit;
	logic               alloc;
	logic [COUNT_W-1:0] count_inc;
	logic [TIME_W-1:0]  elapsed;
	logic               in_window;
	logic [COUNT_W-1:0] count_next;
	sra_token_t         tok_next;

	assign live      = tok_in.valid && !tok_in.done;
	assign hit       = live && valid_q && (key_q == tok_in.src_ip);
	assign alloc     = live && !valid_q;
	assign count_inc = (count_q == COUNT_MAX) ? count_q : count_q + COUNT_W'(1);
	assign elapsed   = tok_in.now_seconds - start_q;
	assign in_window = elapsed < TIME_W'(cfg.window_seconds);
	assign count_next = in_window ? count_inc : '0;

	always_comb begin
		tok_next = tok_in;
		if (hit) begin
			tok_next.done         = 1'b1;
			tok_next.alarm        = in_window && (count_inc > cfg.alarm_threshold);
			tok_next.packet_count = count_next;
			tok_next.entry_index  = INDEX_W'(INDEX);
		end else if (alloc) begin
			tok_next.done         = 1'b1;
			tok_next.packet_count = COUNT_W'(1);
			tok_next.entry_index  = INDEX_W'(INDEX);
			tok_next.new_source   = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_q   <= '0;
		end else if (advance) begin
			tok_q <= tok_next;
			if (alloc) begin
				valid_q <= 1'b1;
			end
		end
	end

	// entry payload, qualified by valid_q
	always_ff @(posedge clk) begin
		if (advance) begin
			if (alloc) begin
				key_q   <= tok_in.src_ip;
				count_q <= COUNT_W'(1);
				start_q <= tok_in.now_seconds;
			end else if (hit) begin
				count_q <= count_next;
				if (!in_window) begin
					start_q <= tok_in.now_seconds;
				end
			end
		end
	end

	assign tok_out = tok_q;

endmodule

[hdl/sra_checker.sv]
module sra_checker
	import sra_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tready,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output beat changed while stalled");

	a_ready_follows_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not track output slot");

	a_full_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[23] |-> m_tdata[22:0] == 23'd0)
		else $error("table full beat carries entry data");

	a_new_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[22] |-> m_tdata[16:1] == 16'd1 && !m_tdata[0])
		else $error("new source beat with wrong count or alarm");

	a_alarm_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[16:1] != 16'd0 && !m_tdata[23])
		else $error("alarm with zero count or full table");

endmodule

bind per_source_rate_alarm sra_checker u_sra_checker (.*);

[verif/per_source_rate_alarm_tb.sv]
`timescale 1ns / 1ps

module per_source_rate_alarm_tb;
	import sra_pkg::*;

	localparam int LATENCY         = TABLE_ENTRIES_DEF + 1;
	localparam int RUN_LIMIT       = 1_000_000;
	localparam int HOLD_CYCLES     = 400;
	localparam int PLAN_ROWS       = 26;
	localparam int ITEMS_PER_PHASE = 300;
	localparam int MAX_PRINTS      = 20;

	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 8'hFF;

	typedef struct packed {
		logic               table_full;
		logic               new_source;
		logic [INDEX_W-1:0] entry_index;
		logic [COUNT_W-1:0] packet_count;
		logic               alarm;
	} alarm_result_t;

	typedef enum logic {ROW_PACKET, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t     kind;
		logic [31:0]   a;
		logic [31:0]   b;
		bit            typed;
		alarm_result_t want;
	} plan_row_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_DATA_W-1:0]   s_tdata   = '0;   // src_ip, now_seconds
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0]  m_tdata;          // alarm, packet_count, entry_index, new_source, table_full
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;

	// shadow of the source table and registers
	logic [KEY_W-1:0]   src_key   [TABLE_ENTRIES_DEF];
	logic [COUNT_W-1:0] src_count [TABLE_ENTRIES_DEF];
	logic [TIME_W-1:0]  src_start [TABLE_ENTRIES_DEF];
	int                 seen_sources = 0;
	logic [COUNT_W-1:0] thr_shadow   = THR_RESET;
	logic [WIN_W-1:0]   win_shadow   = WIN_RESET;

	alarm_result_t pending_results[$];
	plan_row_t     plan [PLAN_ROWS];

	int          error_count   = 0;
	int          packets_sent  = 0;
	int          alarms_seen   = 0;
	int          restarts_seen = 0;
	int          full_seen     = 0;
	int          new_seen      = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          hold_asked    = 0;
	int          hold_done     = 0;
	int          hold_left     = 0;
	int          cycle_count   = 0;
	logic [31:0] clock_now     = 32'd1000;

	per_source_rate_alarm uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RUN_LIMIT) begin
			$display("run stopped after %0d cycles", cycle_count);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic alarm_result_t outcome(int a, int c, int i, int n, int f);
		alarm_result_t r;
		r.alarm        = a[0];
		r.packet_count = c[COUNT_W-1:0];
		r.entry_index  = i[INDEX_W-1:0];
		r.new_source   = n[0];
		r.table_full   = f[0];
		return r;
	endfunction

	function automatic alarm_result_t score_packet(logic [KEY_W-1:0] ip, logic [TIME_W-1:0] ts);
		alarm_result_t      r;
		int                 slot;
		int                 i;
		bit                 hit;
		logic [COUNT_W-1:0] c;
		logic [TIME_W-1:0]  elapsed;
		r    = '0;
		hit  = 1'b0;
		slot = 0;
		for (i = 0; i < seen_sources; i++)
			if (!hit && src_key[i] == ip) begin
				hit  = 1'b1;
				slot = i;
			end
		if (hit) begin
			c       = src_count[slot];
			elapsed = ts - src_start[slot];
			if (c != COUNT_MAX)
				c = c + 1'b1;
			if (elapsed < {{(TIME_W-WIN_W){1'b0}}, win_shadow}) begin
				r.alarm = (c > thr_shadow);
			end else begin
				src_start[slot] = ts;
				c = '0;
			end
			src_count[slot] = c;
			r.packet_count  = c;
			r.entry_index   = slot[INDEX_W-1:0];
		end else if (seen_sources < TABLE_ENTRIES_DEF) begin
			src_key[seen_sources]   = ip;
			src_count[seen_sources] = COUNT_W'(1);
			src_start[seen_sources] = ts;
			r.packet_count = COUNT_W'(1);
			r.entry_index  = seen_sources[INDEX_W-1:0];
			r.new_source   = 1'b1;
			seen_sources++;
		end else begin
			r.table_full = 1'b1;
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		error_count++;
		if (error_count <= MAX_PRINTS)
			$display("mismatch at cycle %0d, %s: got %0h, expected %0h",
				cycle_count, what, got, want);
	endtask

	task automatic push_packet(input logic [KEY_W-1:0] ip, input logic [TIME_W-1:0] ts,
			input bit typed, input alarm_result_t typed_want);
		alarm_result_t predicted;
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {ts, ip};
		do @(posedge clk); while (!s_tready);
		predicted = score_packet(ip, ts);
		pending_results.push_back(typed ? typed_want : predicted);
		packets_sent++;
	endtask

	task automatic quiesce();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_ALARM_THRESHOLD: thr_shadow = data;
			REG_WINDOW_SECONDS:  win_shadow = data[WIN_W-1:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// output side: random stalls plus one long hold on request
	always @(posedge clk) begin
		if (hold_asked != hold_done) begin
			hold_done <= hold_asked;
			hold_left <= HOLD_CYCLES;
			m_tready  <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin : result_check
		alarm_result_t got;
		alarm_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = alarm_result_t'(m_tdata);
			if (pending_results.size() == 0) begin
				report_mismatch("beat with nothing pending", 32'(m_tdata), 32'd0);
			end else begin
				want = pending_results.pop_front();
				if (got.alarm !== want.alarm)
					report_mismatch("alarm", 32'(got.alarm), 32'(want.alarm));
				if (got.packet_count !== want.packet_count)
					report_mismatch("packet_count", 32'(got.packet_count),
						32'(want.packet_count));
				if (got.entry_index !== want.entry_index)
					report_mismatch("entry_index", 32'(got.entry_index),
						32'(want.entry_index));
				if (got.new_source !== want.new_source)
					report_mismatch("new_source", 32'(got.new_source), 32'(want.new_source));
				if (got.table_full !== want.table_full)
					report_mismatch("table_full", 32'(got.table_full), 32'(want.table_full));
				alarms_seen += int'(want.alarm);
				new_seen    += int'(want.new_source);
				full_seen   += int'(want.table_full);
				if (!want.new_source && !want.table_full && want.packet_count == 0)
					restarts_seen++;
			end
		end
	end

	initial begin
		int          row;
		int          phase;
		int          k;
		int          pick;
		logic [31:0] ip;
		plan = '{
			'{ROW_PACKET, 32'h0000_0000, 32'h0000_0000, 1'b1, outcome(0, 1, 0, 1, 0)},
			'{ROW_PACKET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, outcome(0, 1, 1, 1, 0)},
			'{ROW_PACKET, 32'h0000_0000, 32'h0000_0001, 1'b1, outcome(0, 2, 0, 0, 0)},
			// elapsed time wraps through zero
			'{ROW_PACKET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, outcome(0, 2, 1, 0, 0)},
			'{ROW_PACKET, 32'h0000_0000, 32'h0000_0002, 1'b1, outcome(0, 0, 0, 0, 0)},
			'{ROW_PACKET, 32'h0000_0000, 32'h0000_0002, 1'b0, '0},
			'{ROW_WRITE,  32'(REG_ALARM_THRESHOLD), 32'h0000, 1'b0, '0},
			'{ROW_PACKET, 32'h0000_0000, 32'h0000_0003, 1'b0, '0},
			// a new source never alarms, even at threshold zero
			'{ROW_PACKET, 32'h1234_5678, 32'h0000_0003, 1'b1, outcome(0, 1, 2, 1, 0)},
			'{ROW_PACKET, 32'hA5A5_5A5A, 32'h0000_0003, 1'b1, outcome(0, 1, 3, 1, 0)},
			'{ROW_WRITE,  32'(REG_WINDOW_SECONDS), 32'h0000, 1'b0, '0},
			'{ROW_PACKET, 32'h0000_0000, 32'h0000_0003, 1'b1, outcome(0, 0, 0, 0, 0)},
			'{ROW_PACKET, 32'h0000_0000, 32'h0000_0003, 1'b1, outcome(0, 0, 0, 0, 0)},
			'{ROW_WRITE,  32'(REG_WINDOW_SECONDS), 32'hFFFF, 1'b0, '0},
			'{ROW_WRITE,  32'(REG_ALARM_THRESHOLD), 32'hFFFF, 1'b0, '0},
			'{ROW_PACKET, 32'h1234_5678, 32'd100, 1'b0, '0},
			'{ROW_WRITE,  32'(REG_UNUSED), 32'h0001, 1'b0, '0},
			'{ROW_PACKET, 32'h1234_5678, 32'd355, 1'b0, '0},
			'{ROW_PACKET, 32'h1234_5678, 32'd355, 1'b0, '0},
			'{ROW_WRITE,  32'(REG_ALARM_THRESHOLD), 32'h0001, 1'b0, '0},
			'{ROW_PACKET, 32'h1234_5678, 32'd356, 1'b0, '0},
			'{ROW_WRITE,  32'(REG_WINDOW_SECONDS), 32'h0001, 1'b0, '0},
			'{ROW_PACKET, 32'h5A5A_A5A5, 32'd356, 1'b1, outcome(0, 1, 4, 1, 0)},
			'{ROW_PACKET, 32'h5A5A_A5A5, 32'd356, 1'b0, '0},
			'{ROW_PACKET, 32'h5A5A_A5A5, 32'd357, 1'b0, '0},
			'{ROW_PACKET, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0, '0}
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 34;
		recv_idle_pct = 85;
		for (row = 0; row < PLAN_ROWS; row++) begin
			if (plan[row].kind == ROW_WRITE) begin
				quiesce();
				write_reg(plan[row].a[CFG_INDEX_W-1:0], plan[row].b[CFG_DATA_W-1:0]);
			end else begin
				push_packet(plan[row].a, plan[row].b, plan[row].typed, plan[row].want);
			end
		end

		for (phase = 0; phase < 3; phase++) begin
			quiesce();
			send_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 85 : 0;
			recv_idle_pct = (phase == 0) ? 85 : (phase == 1) ? 34 : 0;
			write_reg(REG_ALARM_THRESHOLD, CFG_DATA_W'($urandom_range(6)));
			write_reg(REG_WINDOW_SECONDS, CFG_DATA_W'($urandom_range(1, 12)));
			if (phase == 2)
				hold_asked++;
			for (k = 0; k < ITEMS_PER_PHASE; k++) begin
				pick = $urandom_range(99);
				if (pick < 3)
					clock_now = $urandom;
				else if (pick < 18)
					clock_now = clock_now + $urandom_range(1, 3);
				pick = $urandom_range(99);
				// fresh addresses fill the table, then hit the full case
				if (seen_sources == 0 || pick < 15)
					ip = $urandom;
				else if (pick < 60)
					ip = src_key[$urandom_range(seen_sources < 4 ? seen_sources - 1 : 3)];
				else
					ip = src_key[$urandom_range(seen_sources - 1)];
				push_packet(ip, clock_now, 1'b0, '0);
			end
		end

		quiesce();
		repeat (4 * LATENCY) @(posedge clk);
		$display("%0d packets: %0d new sources, %0d alarms, %0d window restarts, %0d table-full",
			packets_sent, new_seen, alarms_seen, restarts_seen, full_seen);
		$display("thresholds 0..65535, windows 0..255, time wrap, %0d-cycle output hold",
			HOLD_CYCLES);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[filelist.f]
hdl/sra_pkg.sv
hdl/sra_cell.sv
hdl/per_source_rate_alarm.sv
hdl/sra_checker.sv
verif/per_source_rate_alarm_tb.sv
